FILE: hw/rtl/fibt_pkg.sv
package fibt_pkg;

  // Table geometry
  localparam int SLOTS  = 16;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [15:0] ECAT_ETHERTYPE = 16'h88A4;

  // Slot status codes; values above complete are stored as written
  typedef logic [2:0] status_t;
  localparam status_t STS_EMPTY = 3'd0;
  localparam status_t STS_ALLOC = 3'd1;
  localparam status_t STS_SENT  = 3'd2;
  localparam status_t STS_RCVD  = 3'd3;
  localparam status_t STS_DONE  = 3'd4;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_SET   = 2'd1,
    OP_SENT  = 2'd2,
    OP_POLL  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    VERD_NONE    = 2'd0,
    VERD_OTHER   = 2'd1,
    VERD_STORED  = 2'd2,
    VERD_ARRIVED = 2'd3
  } verdict_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_POLL_RD1,
    S_POLL_RD2,
    S_EXEC,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    RD_SCAN,
    RD_SLOT,
    RD_FSLOT
  } rd_sel_t;

  typedef struct packed {
    op_t         operation;
    logic [3:0]  slot;
    logic [2:0]  status_value;
    logic        frame_present;
    logic [15:0] ethertype;
    logic [7:0]  frame_slot;
  } fibt_in_t;

  typedef struct packed {
    logic [3:0]  allocated_slot;
    verdict_t    verdict;
    logic [3:0]  store_slot;
    logic        store_enable;
    logic [15:0] ecat_frames;
  } fibt_out_t;

  // Controller to datapath
  typedef struct packed {
    logic    load_in;
    logic    scan_init;
    logic    scan_adv;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    cap_slot;
    logic    exec;
    logic    load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_t  in_op;
    logic scan_empty;
    logic scan_end;
    logic out_free;
  } sts_t;

endpackage

FILE: hw/rtl/frame_index_buffer_tracker.sv
// Frame slot status tracker for indexed frame buffers.
// Input channel (in_valid/in_ready/in_data) takes one operation per beat:
// allocate, set status, mark sent or receive poll. Result channel
// (out_valid/out_ready/out_data) returns exactly one beat per operation.
// Items are handled one at a time; in_ready is high while the controller
// is idle, even if the previous result is still waiting in the output
// register.
// From accept to out_valid: set status and mark sent pass through the
// execute and done states; receive poll first makes two status table
// reads; allocate makes one read-and-check pair per slot inspected (1 to
// SLOTS), since the scan reads one slot per read from the status table.
// The next item is taken in the cycle after the result is loaded.
// If the receiver stalls with a result still held, the next item runs to
// completion and then waits until the held beat is taken.
// Reset (synchronous, rst_n low) marks every slot empty through per-slot
// valid bits, zeroes the last-allocated slot and the frame counter, and
// drops any pending result; no clearing pass is needed.
module frame_index_buffer_tracker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  fibt_pkg::fibt_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output fibt_pkg::fibt_out_t out_data
);
  import fibt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  fibt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fibt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

FILE: hw/rtl/fibt_ctrl.sv
module fibt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  fibt_pkg::sts_t sts,
  output fibt_pkg::cmd_t cmd
);
  import fibt_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (sts.in_op)
            OP_ALLOC: state_nxt = S_SCAN_RD;
            OP_POLL:  state_nxt = S_POLL_RD1;
            default:  state_nxt = S_EXEC;
          endcase
        end
      end
      S_SCAN_RD:  state_nxt = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (sts.scan_empty || sts.scan_end) begin
          state_nxt = S_EXEC;
        end else begin
          state_nxt = S_SCAN_RD;
        end
      end
      S_POLL_RD1: state_nxt = S_POLL_RD2;
      S_POLL_RD2: state_nxt = S_EXEC;
      S_EXEC:     state_nxt = S_DONE;
      S_DONE: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    cmd.rd_sel = RD_SCAN;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_in   = in_valid;
        cmd.scan_init = in_valid;
      end
      S_SCAN_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_SCAN;
      end
      S_SCAN_CHK: begin
        // advance past a busy slot; at the end this wraps back to the start
        cmd.scan_adv = !sts.scan_empty;
      end
      S_POLL_RD1: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_SLOT;
      end
      S_POLL_RD2: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_sel   = RD_FSLOT;
        cmd.cap_slot = 1'b1;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
      end
      S_DONE: begin
        cmd.load_out = sts.out_free;
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_scan_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN_CHK && sts.scan_end) |=> state_r == S_EXEC)
    else $error("slot scan ran past the last slot");

  a_exec_once: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EXEC |=> state_r == S_DONE)
    else $error("execute step not followed by result hand-off");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r != S_IDLE)
    else $error("accepted beat did not start work");
`endif

endmodule

FILE: hw/rtl/fibt_dp.sv
module fibt_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  fibt_pkg::fibt_in_t  in_data,
  input  logic                out_ready,
  output logic                out_valid,
  output fibt_pkg::fibt_out_t out_data,
  input  fibt_pkg::cmd_t      cmd,
  output fibt_pkg::sts_t      sts
);
  import fibt_pkg::*;

  fibt_in_t             in_r;
  logic [SLOT_W-1:0]    last_slot_r;
  logic [SLOT_W-1:0]    last_slot_nxt;
  logic [SLOT_W-1:0]    idx_r;
  logic [SLOT_W-1:0]    cnt_r;
  logic [15:0]          ecat_cnt_r;
  logic [15:0]          ecat_cnt_nxt;
  logic                 slot_rcvd_r;
  fibt_out_t            res_r;
  fibt_out_t            res_nxt;
  fibt_out_t            out_r;
  logic                 out_valid_r;

  // Status table with per-entry valid bits; an unwritten entry reads empty
  status_t              mem [SLOTS];
  logic [SLOTS-1:0]     vld_r;
  status_t              rd_data_r;
  logic                 rd_vld_r;
  status_t              rd_status;
  logic [SLOT_W-1:0]    rd_addr;
  logic                 wr_en;
  logic [SLOT_W-1:0]    wr_addr;
  status_t              wr_data;

  logic [SLOT_W-1:0]    slot_idx;
  logic [SLOT_W-1:0]    fslot_idx;
  logic                 slot_in_range;
  logic                 fslot_in_range;
  logic                 fslot_match;
  logic                 is_ecat;

  function automatic logic [SLOT_W-1:0] next_idx(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(SLOTS - 1)) ? '0 : s + 1'b1;
  endfunction

  assign slot_idx       = SLOT_W'(in_r.slot);
  assign fslot_idx      = SLOT_W'(in_r.frame_slot);
  assign slot_in_range  = (32'(in_r.slot) < 32'(SLOTS));
  assign fslot_in_range = (32'(in_r.frame_slot) < 32'(SLOTS));
  assign fslot_match    = (in_r.frame_slot == 8'(in_r.slot));
  assign is_ecat        = in_r.frame_present && (in_r.ethertype == ECAT_ETHERTYPE);

  assign rd_status = rd_vld_r ? rd_data_r : STS_EMPTY;

  // Select the read address
  always_comb begin
    case (cmd.rd_sel)
      RD_SCAN:  rd_addr = idx_r;
      RD_SLOT:  rd_addr = slot_idx;
      RD_FSLOT: rd_addr = fslot_idx;
      default:  rd_addr = idx_r;
    endcase
  end

  // Table storage: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // Latch the incoming beat and walk the scan pointer
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_r <= in_data;
    end
    if (cmd.scan_init) begin
      idx_r <= next_idx(last_slot_r);
      cnt_r <= '0;
    end else if (cmd.scan_adv) begin
      idx_r <= next_idx(idx_r);
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.cap_slot) begin
      slot_rcvd_r <= slot_in_range && (rd_status == STS_RCVD);
    end
    if (cmd.exec) begin
      res_r <= res_nxt;
    end
  end

  // Execute the operation: at most one table write and the result fields
  always_comb begin
    wr_en         = 1'b0;
    wr_addr       = idx_r;
    wr_data       = STS_ALLOC;
    res_nxt       = '0;
    ecat_cnt_nxt  = ecat_cnt_r;
    last_slot_nxt = last_slot_r;
    if (cmd.exec) begin
      case (in_r.operation)
        OP_ALLOC: begin
          wr_en                  = 1'b1;
          wr_addr                = idx_r;
          wr_data                = STS_ALLOC;
          last_slot_nxt          = idx_r;
          res_nxt.allocated_slot = 4'(idx_r);
        end
        OP_SET: begin
          wr_en   = slot_in_range;
          wr_addr = slot_idx;
          wr_data = in_r.status_value;
        end
        OP_SENT: begin
          wr_en   = slot_in_range;
          wr_addr = slot_idx;
          wr_data = STS_SENT;
        end
        OP_POLL: begin
          if (slot_rcvd_r) begin
            // awaited frame was parked by an earlier poll
            wr_en           = 1'b1;
            wr_addr         = slot_idx;
            wr_data         = STS_DONE;
            res_nxt.verdict = VERD_STORED;
          end else if (in_r.frame_present) begin
            res_nxt.verdict = VERD_OTHER;
            if (is_ecat) begin
              ecat_cnt_nxt = ecat_cnt_r + 16'd1;
              if (fslot_match) begin
                res_nxt.verdict = VERD_ARRIVED;
                if (slot_in_range) begin
                  wr_en                = 1'b1;
                  wr_addr              = slot_idx;
                  wr_data              = STS_DONE;
                  res_nxt.store_slot   = in_r.slot;
                  res_nxt.store_enable = 1'b1;
                end
              end else if (fslot_in_range && rd_status == STS_SENT) begin
                // early answer for another outstanding slot: park it
                wr_en                = 1'b1;
                wr_addr              = fslot_idx;
                wr_data              = STS_RCVD;
                res_nxt.store_slot   = 4'(fslot_idx);
                res_nxt.store_enable = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
      // report the frame count as it stands after this operation
      res_nxt.ecat_frames = ecat_cnt_nxt;
    end
  end

  // Control state: last handed-out slot, frame counter, result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_slot_r <= '0;
      ecat_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      last_slot_r <= last_slot_nxt;
      ecat_cnt_r  <= ecat_cnt_nxt;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r <= res_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data       = out_r;
  assign sts.in_op      = in_data.operation;
  assign sts.scan_empty = (rd_status == STS_EMPTY);
  assign sts.scan_end   = (cnt_r == SLOT_W'(SLOTS - 1));
  assign sts.out_free   = !out_valid_r || out_ready;

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load_out && out_valid_r && !out_ready))
    else $error("result register overwritten before beat was taken");

  a_store_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.store_enable) |->
      (out_r.verdict == VERD_OTHER || out_r.verdict == VERD_ARRIVED))
    else $error("store requested with a verdict that takes no frame");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && ecat_cnt_r != $past(ecat_cnt_r)) |->
      (ecat_cnt_r == $past(ecat_cnt_r) + 16'd1 && $past(cmd.exec)))
    else $error("frame counter moved other than by one on execute");
`endif

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import fibt_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  fibt_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  fibt_out_t out_data;

  frame_index_buffer_tracker u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Tracker image: slot table, last claimed slot, EtherCAT frame counter
  status_t     slot_state [SLOTS] = '{default: STS_EMPTY};
  int          last_claimed = 0;
  logic [15:0] ecat_seen = '0;

  fibt_out_t pending_results [$];
  fibt_out_t want;
  int        err_count = 0;
  int        item_total = 0;
  int        stall_left = 0;
  bit        steady = 1'b0;

  // Coverage tallies for the closing summary
  int op_seen [4] = '{default: 0};
  int verdict_seen [4] = '{default: 0};
  int full_allocs = 0;
  int early_answers = 0;

  always #5 clk = ~clk;

  // Gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Advance the tracker image by one operation and return the result beat
  function automatic fibt_out_t predict_result(fibt_in_t it);
    fibt_out_t r;
    int idx;
    int steps;
    r = '0;
    op_seen[it.operation]++;
    case (it.operation)
      OP_ALLOC: begin
        idx = (last_claimed + 1) % SLOTS;
        steps = 0;
        while (slot_state[idx] != STS_EMPTY && steps < SLOTS) begin
          idx = (idx + 1) % SLOTS;
          steps++;
        end
        if (steps == SLOTS) full_allocs++;
        slot_state[idx] = STS_ALLOC;
        last_claimed = idx;
        r.allocated_slot = 4'(idx);
      end
      OP_SET: begin
        slot_state[it.slot] = it.status_value;
      end
      OP_SENT: begin
        slot_state[it.slot] = STS_SENT;
      end
      default: begin
        if (slot_state[it.slot] == STS_RCVD) begin
          // frame parked by an earlier poll completes the slot
          slot_state[it.slot] = STS_DONE;
          r.verdict = VERD_STORED;
        end else if (it.frame_present) begin
          r.verdict = VERD_OTHER;
          if (it.ethertype == ECAT_ETHERTYPE) begin
            ecat_seen = ecat_seen + 16'd1;
            if (it.frame_slot == {4'd0, it.slot}) begin
              slot_state[it.slot] = STS_DONE;
              r.verdict = VERD_ARRIVED;
              r.store_slot = it.slot;
              r.store_enable = 1'b1;
            end else if (it.frame_slot < SLOTS &&
                         slot_state[it.frame_slot] == STS_SENT) begin
              // frame answers another outstanding slot: park it there
              slot_state[it.frame_slot] = STS_RCVD;
              r.store_slot = it.frame_slot[3:0];
              r.store_enable = 1'b1;
              early_answers++;
            end
          end
        end
        verdict_seen[r.verdict]++;
      end
    endcase
    r.ecat_frames = ecat_seen;
    return r;
  endfunction

  function automatic fibt_in_t random_item();
    fibt_in_t it;
    it.operation     = op_t'($urandom_range(0, 3));
    it.slot          = 4'($urandom);
    it.status_value  = 3'($urandom);
    it.frame_present = 1'($urandom);
    it.ethertype     = ($urandom_range(0, 2) == 0) ? ECAT_ETHERTYPE : 16'($urandom);
    it.frame_slot    = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 15))
                                                   : 8'($urandom);
    return it;
  endfunction

  function automatic fibt_in_t cmd_item(op_t op, logic [3:0] slot);
    fibt_in_t it;
    it = random_item();
    it.operation = op;
    it.slot = slot;
    return it;
  endfunction

  function automatic fibt_in_t poll_item(logic [3:0] slot, logic present,
                                         logic [15:0] etype, logic [7:0] fslot);
    fibt_in_t it;
    it = cmd_item(OP_POLL, slot);
    it.frame_present = present;
    it.ethertype = etype;
    it.frame_slot = fslot;
    return it;
  endfunction

  // Random slot currently marked sent, other than skip; -1 if none
  function automatic int pick_sent(int skip);
    int found [$];
    foreach (slot_state[i])
      if (slot_state[i] == STS_SENT && i != skip) found.push_back(i);
    if (found.size() == 0) return -1;
    return found[$urandom_range(0, found.size() - 1)];
  endfunction

  function automatic bit pick_empty_exists();
    foreach (slot_state[i])
      if (slot_state[i] == STS_EMPTY) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void check_field(string name, int exp_val, int got_val);
    if (exp_val != got_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, got_val);
      err_count++;
    end
  endfunction

  // Offer one beat after a random gap (none in a steady stretch); hold valid and payload until taken
  task automatic send_item(input fibt_in_t item);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_result(item));
    item_total++;
  endtask

  // Hold off the sender until every expected beat has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic set_status(logic [3:0] slot, status_t value);
    fibt_in_t it;
    it = cmd_item(OP_SET, slot);
    it.status_value = value;
    send_item(it);
  endtask

  // Receiver: random stalls, no new stall starts while a steady stretch runs
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (!steady && $urandom_range(0, 3) == 0) begin
      stall_left <= pick_gap();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: %p", out_data);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("allocated_slot", want.allocated_slot, out_data.allocated_slot);
        check_field("verdict", want.verdict, out_data.verdict);
        check_field("store_slot", want.store_slot, out_data.store_slot);
        check_field("store_enable", want.store_enable, out_data.store_enable);
        check_field("ecat_frames", want.ecat_frames, out_data.ecat_frames);
      end
    end
  end

  // Allocation from reset and status writes, odd codes included
  task automatic test_alloc_and_status();
    repeat (3) send_item(cmd_item(OP_ALLOC, 4'($urandom)));
    set_status(4'd0, status_t'(3'd7));
    set_status(4'd15, status_t'(3'd5));
    set_status(4'd4, STS_DONE);
    set_status(4'd5, STS_RCVD);
    set_status(4'd6, STS_EMPTY);
    wait_drained();
  endtask

  // Every poll outcome: no frame, foreign frame, early answer, stored, match
  task automatic test_poll_cases();
    send_item(cmd_item(OP_SENT, 4'd2));
    send_item(cmd_item(OP_SENT, 4'd3));
    send_item(cmd_item(OP_SENT, 4'd15));
    send_item(poll_item(4'd2, 1'b0, 16'hFFFF, 8'hFF));
    send_item(poll_item(4'd2, 1'b1, 16'h0000, 8'd2));
    send_item(poll_item(4'd2, 1'b1, ECAT_ETHERTYPE, 8'd3));
    send_item(poll_item(4'd3, 1'b1, ECAT_ETHERTYPE, 8'd3));
    send_item(poll_item(4'd2, 1'b1, ECAT_ETHERTYPE, 8'd2));
    send_item(poll_item(4'd5, 1'b0, 16'h0000, 8'h00));
    send_item(poll_item(4'd4, 1'b1, ECAT_ETHERTYPE, 8'hFF));
    send_item(poll_item(4'd4, 1'b1, ECAT_ETHERTYPE, 8'd15));
    send_item(poll_item(4'd15, 1'b0, 16'hFFFF, 8'h00));
    send_item(poll_item(4'd0, 1'b1, ECAT_ETHERTYPE, 8'd0));
    send_item(poll_item(4'd6, 1'b1, ECAT_ETHERTYPE, 8'd4));
    wait_drained();
  endtask

  // Fill the table, allocate twice with no empty slot left, then free slot 7 and allocate once more
  task automatic test_full_table();
    while (pick_empty_exists()) send_item(cmd_item(OP_ALLOC, 4'($urandom)));
    repeat (2) send_item(cmd_item(OP_ALLOC, 4'($urandom)));
    set_status(4'd7, STS_EMPTY);
    send_item(cmd_item(OP_ALLOC, 4'($urandom)));
    wait_drained();
  endtask

  // One frame exchange: claim, transmit, poll until complete, maybe release
  task automatic run_exchange();
    logic [3:0] mine;
    int other;
    steady = ($urandom_range(0, 4) == 0);
    send_item(cmd_item(OP_ALLOC, 4'($urandom)));
    mine = 4'(last_claimed);
    send_item(cmd_item(OP_SENT, mine));
    if ($urandom_range(0, 2) == 0) send_item(cmd_item(OP_SENT, 4'($urandom)));
    other = pick_sent(mine);
    case ($urandom_range(0, 3))
      0: begin
      end
      1: begin
        if (other >= 0) begin
          send_item(poll_item(mine, 1'b1, ECAT_ETHERTYPE, 8'(other)));
          send_item(poll_item(4'(other), 1'($urandom), 16'($urandom), 8'($urandom)));
        end
      end
      2: begin
        send_item(poll_item(mine, 1'b0, 16'($urandom), 8'($urandom)));
      end
      default: begin
        send_item(poll_item(mine, 1'b1, 16'($urandom), {4'd0, mine}));
      end
    endcase
    send_item(poll_item(mine, 1'b1, ECAT_ETHERTYPE, {4'd0, mine}));
    if ($urandom_range(0, 1) == 0) set_status(mine, STS_EMPTY);
  endtask

  // Mostly well-formed exchanges, the rest unrelated random beats
  task automatic test_random_traffic();
    while (item_total < 550) begin
      if ($urandom_range(0, 3) != 0) begin
        run_exchange();
      end else begin
        steady = 1'b0;
        repeat ($urandom_range(1, 3)) send_item(random_item());
      end
      if ($urandom_range(0, 60) == 0) wait_drained();
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_alloc_and_status();
    test_poll_cases();
    test_full_table();
    test_random_traffic();
    wait_drained();
    repeat (40) @(posedge clk);
    $display("Ran %0d operations: %0d allocate (%0d on a full table), %0d set, %0d sent, %0d poll",
             item_total, op_seen[OP_ALLOC], full_allocs, op_seen[OP_SET],
             op_seen[OP_SENT], op_seen[OP_POLL]);
    $display("Polls: %0d no frame, %0d other, %0d from stored, %0d on arrival; %0d parked early",
             verdict_seen[VERD_NONE], verdict_seen[VERD_OTHER],
             verdict_seen[VERD_STORED], verdict_seen[VERD_ARRIVED], early_answers);
    if (err_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
